>>> sv/msto_pkg.sv
package msto_pkg;

  localparam int PHASE_FRAC_BITS_DEF = 24;
  localparam int SAMPLE_BITS_DEF     = 16;
  localparam int AUX_W               = 32;
  localparam int LEVEL_W             = 16;
  localparam int MODE_W              = 2;
  localparam int CFG_IDX_W           = 4;
  localparam int STEP_W              = 3;

  typedef enum logic [MODE_W-1:0] {
    MODE_RAMP = 2'd0,
    MODE_GATE = 2'd1,
    MODE_TRI  = 2'd2,
    MODE_FLAT = 2'd3
  } mode_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_WAVE_MODE   = 4'd0,
    CFG_PHASE_INC   = 4'd1,
    CFG_AUX_RATE    = 4'd2,
    CFG_SHAPE_A     = 4'd3,
    CFG_SHAPE_B     = 4'd4,
    CFG_LEVEL_MIN   = 4'd5,
    CFG_LEVEL_MAX   = 4'd6,
    CFG_START_PHASE = 4'd7
  } cfg_idx_t;

  // step advance condition of a control word
  typedef enum logic [1:0] {
    COND_ALWAYS = 2'd0,
    COND_IN     = 2'd1,
    COND_OUT    = 2'd2
  } cond_t;

  typedef struct packed {
    logic ld_phase;
    logic ld_region;
    logic ld_prod;
    logic ld_mul;
    logic ld_out;
  } dp_ctrl_t;

  typedef struct packed {
    cond_t             cond;
    dp_ctrl_t          en;
    logic [STEP_W-1:0] next;
  } uword_t;

  localparam logic [STEP_W-1:0] STEP_ACCEPT    = 3'd0;
  localparam logic [STEP_W-1:0] STEP_REGION    = 3'd1;
  localparam logic [STEP_W-1:0] STEP_MUL_RATE  = 3'd2;
  localparam logic [STEP_W-1:0] STEP_MUL_LEVEL = 3'd3;
  localparam logic [STEP_W-1:0] STEP_OUTPUT    = 3'd4;

  // control store: one word per step
  function automatic uword_t ucode(input logic [STEP_W-1:0] step);
    uword_t uw;
    uw = '0;
    unique case (step)
      STEP_ACCEPT: begin
        uw.cond        = COND_IN;
        uw.en.ld_phase = 1'b1;
        uw.next        = STEP_REGION;
      end
      STEP_REGION: begin
        uw.cond         = COND_ALWAYS;
        uw.en.ld_region = 1'b1;
        uw.next         = STEP_MUL_RATE;
      end
      STEP_MUL_RATE: begin
        uw.cond       = COND_ALWAYS;
        uw.en.ld_prod = 1'b1;
        uw.next       = STEP_MUL_LEVEL;
      end
      STEP_MUL_LEVEL: begin
        uw.cond      = COND_ALWAYS;
        uw.en.ld_mul = 1'b1;
        uw.next      = STEP_OUTPUT;
      end
      STEP_OUTPUT: begin
        uw.cond      = COND_OUT;
        uw.en.ld_out = 1'b1;
        uw.next      = STEP_ACCEPT;
      end
      default: begin
        uw.cond = COND_ALWAYS;
        uw.next = STEP_ACCEPT;
      end
    endcase
    return uw;
  endfunction

endpackage

>>> sv/msto_datapath.sv
module msto_datapath #(
  parameter int PHASE_FRAC_BITS = msto_pkg::PHASE_FRAC_BITS_DEF,
  parameter int SAMPLE_BITS     = msto_pkg::SAMPLE_BITS_DEF,
  localparam int PW             = PHASE_FRAC_BITS + 1
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  msto_pkg::dp_ctrl_t                  ctrl,
  input  logic                                restart,
  input  msto_pkg::mode_t                     mode,
  input  logic [PW-1:0]                       phase_inc,
  input  logic [msto_pkg::AUX_W-1:0]          aux_rate,
  input  logic [PW-1:0]                       shape_a,
  input  logic [PW-1:0]                       shape_b,
  input  logic [PW-1:0]                       start_phase,
  input  logic signed [msto_pkg::LEVEL_W-1:0] level_min,
  input  logic signed [msto_pkg::LEVEL_W-1:0] level_max,
  output logic signed [SAMPLE_BITS-1:0]       sample,
  output logic [PW-1:0]                       phase_now
);
  import msto_pkg::*;

  localparam int TW  = ((PW > AUX_W) ? PW : AUX_W) + 2;
  localparam int PRW = AUX_W + PW;
  localparam int WW  = AUX_W + 2;
  localparam int DW  = LEVEL_W + 1;
  localparam int MW  = WW + 1 + DW;
  localparam int SW0 = MW + 1;
  localparam int SW  = (SW0 - PHASE_FRAC_BITS > SAMPLE_BITS) ? SW0
                                                            : PHASE_FRAC_BITS + SAMPLE_BITS + 1;
  localparam int QW  = SW - PHASE_FRAC_BITS;

  localparam logic [PW-1:0] ONE  = PW'(1) << PHASE_FRAC_BITS;
  localparam logic [PW-1:0] HALF = ONE >> 1;
  localparam logic signed [QW-1:0] SAT_HI =
    {{(QW-SAMPLE_BITS+1){1'b0}}, {(SAMPLE_BITS-1){1'b1}}};
  localparam logic signed [QW-1:0] SAT_LO = ~SAT_HI;

  logic [PW-1:0]           phase_r, phase_nxt;
  logic                    rising_r, rising_nxt;
  logic [PW-1:0]           op_r, op_nxt;
  logic                    lt_a_r, lt_b_r;
  logic [PRW-1:0]          prod_r;
  logic signed [MW-1:0]    mul_r, mul_nxt;
  logic signed [SAMPLE_BITS-1:0] sample_r, sample_nxt;
  logic [PW-1:0]           phase_out_r;

  // phase step
  logic [PW-1:0]        base;
  logic                 rise;
  logic signed [TW-1:0] tri_p;
  logic [PW-1:0]        tri_phase;
  logic                 tri_rise;
  logic [PW:0]          sum_p;
  logic [PW-1:0]        wrap_phase;

  always_comb begin
    base  = restart ? start_phase : phase_r;
    rise  = restart ? (start_phase < shape_a) : rising_r;
    tri_p = rise ? $signed(TW'(base)) + $signed(TW'(phase_inc))
                 : $signed(TW'(base)) - $signed(TW'(aux_rate));
    if (tri_p >= $signed(TW'(ONE))) begin
      tri_phase = ONE;
      tri_rise  = 1'b0;
    end else if (tri_p <= $signed(TW'(0))) begin
      tri_phase = '0;
      tri_rise  = 1'b1;
    end else begin
      tri_phase = tri_p[PW-1:0];
      tri_rise  = rise;
    end
    sum_p = {1'b0, base} + {1'b0, phase_inc};
    // wrap into [0, 1]: a nonzero exact multiple of one lands on one
    if (sum_p > {1'b0, ONE}) begin
      wrap_phase = (sum_p[PHASE_FRAC_BITS-1:0] == '0) ? ONE
                                                      : {1'b0, sum_p[PHASE_FRAC_BITS-1:0]};
    end else begin
      wrap_phase = sum_p[PW-1:0];
    end
    if (mode == MODE_TRI) begin
      phase_nxt  = tri_phase;
      rising_nxt = tri_rise;
    end else begin
      phase_nxt  = wrap_phase;
      rising_nxt = rise;
    end
  end

  // region of the new phase and multiplier operand
  logic lt_a, lt_b;
  always_comb begin
    lt_a   = phase_r < shape_a;
    lt_b   = phase_r < shape_b;
    op_nxt = lt_a ? phase_r : phase_r - shape_b;
  end

  // waveform value and level scaling
  logic [AUX_W:0]         slope;
  logic [WW-1:0]          w;
  logic signed [WW:0]     w_s;
  logic signed [DW-1:0]   diff;

  always_comb begin
    slope = prod_r[PRW-1:PHASE_FRAC_BITS];
    unique case (mode)
      MODE_RAMP, MODE_TRI: w = WW'(phase_r);
      MODE_GATE:           w = lt_a_r ? WW'(ONE) : '0;
      MODE_FLAT: begin
        if (lt_a_r) begin
          w = WW'(slope);
        end else if (lt_b_r) begin
          w = WW'(HALF);
        end else begin
          w = WW'(slope) + WW'(HALF);
        end
      end
      default:             w = '0;
    endcase
    w_s     = $signed({1'b0, w});
    diff    = DW'(level_max) - DW'(level_min);
    mul_nxt = w_s * diff;
  end

  // add the base level, divide by one toward zero, saturate
  logic signed [SW-1:0] sum_lvl;
  logic signed [QW-1:0] q;
  logic                 neg_adj;

  always_comb begin
    sum_lvl = SW'(mul_r) + (SW'(level_min) <<< PHASE_FRAC_BITS);
    neg_adj = sum_lvl[SW-1] && (sum_lvl[PHASE_FRAC_BITS-1:0] != '0);
    q       = $signed(sum_lvl[SW-1:PHASE_FRAC_BITS]) + $signed({{(QW-1){1'b0}}, neg_adj});
    if (q > SAT_HI) begin
      sample_nxt = SAT_HI[SAMPLE_BITS-1:0];
    end else if (q < SAT_LO) begin
      sample_nxt = SAT_LO[SAMPLE_BITS-1:0];
    end else begin
      sample_nxt = q[SAMPLE_BITS-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= '0;
      rising_r <= 1'b1;
    end else if (ctrl.ld_phase) begin
      phase_r  <= phase_nxt;
      rising_r <= rising_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.ld_region) begin
      op_r   <= op_nxt;
      lt_a_r <= lt_a;
      lt_b_r <= lt_b;
    end
    if (ctrl.ld_prod) begin
      prod_r <= PRW'(aux_rate) * PRW'(op_r);
    end
    if (ctrl.ld_mul) begin
      mul_r <= mul_nxt;
    end
    if (ctrl.ld_out) begin
      sample_r    <= sample_nxt;
      phase_out_r <= phase_r;
    end
  end

  assign sample    = sample_r;
  assign phase_now = phase_out_r;

endmodule

>>> sv/multi_shape_test_oscillator_unit.sv
// the 5-word control program (phase step, region, rate multiply, level multiply,
//   output) takes a request in its first word and registers the result in its last;
//   the next request waits for the output word, which itself waits on a stalled result
// a new request is taken while the previous result still waits in the output register
// reset: synchronous, clears the sequencer, the output valid, phase to 0 and the
//   registers to their defaults (shape_a and shape_b at one half)
module multi_shape_test_oscillator_unit #(
  parameter int PHASE_FRAC_BITS = msto_pkg::PHASE_FRAC_BITS_DEF,
  parameter int SAMPLE_BITS     = msto_pkg::SAMPLE_BITS_DEF,
  localparam int PW             = PHASE_FRAC_BITS + 1,
  localparam int CDW            = (PW > msto_pkg::AUX_W) ? PW : msto_pkg::AUX_W
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic                             in_restart,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic signed [SAMPLE_BITS-1:0]    out_sample,
  output logic [PW-1:0]                    out_phase_now,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [msto_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [CDW-1:0]                   cfg_wdata
);
  import msto_pkg::*;

  localparam logic [PW-1:0] HALF = PW'(1) << (PHASE_FRAC_BITS - 1);

  mode_t                      wave_mode_r;
  logic [PW-1:0]              phase_inc_r;
  logic [AUX_W-1:0]           aux_rate_r;
  logic [PW-1:0]              shape_a_r;
  logic [PW-1:0]              shape_b_r;
  logic signed [LEVEL_W-1:0]  level_min_r;
  logic signed [LEVEL_W-1:0]  level_max_r;
  logic [PW-1:0]              start_phase_r;

  assign cfg_ready = rst_n;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wave_mode_r   <= MODE_RAMP;
      phase_inc_r   <= '0;
      aux_rate_r    <= '0;
      shape_a_r     <= HALF;
      shape_b_r     <= HALF;
      level_min_r   <= '0;
      level_max_r   <= '0;
      start_phase_r <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_WAVE_MODE:   wave_mode_r   <= mode_t'(cfg_wdata[MODE_W-1:0]);
        CFG_PHASE_INC:   phase_inc_r   <= cfg_wdata[PW-1:0];
        CFG_AUX_RATE:    aux_rate_r    <= cfg_wdata[AUX_W-1:0];
        CFG_SHAPE_A:     shape_a_r     <= cfg_wdata[PW-1:0];
        CFG_SHAPE_B:     shape_b_r     <= cfg_wdata[PW-1:0];
        CFG_LEVEL_MIN:   level_min_r   <= $signed(cfg_wdata[LEVEL_W-1:0]);
        CFG_LEVEL_MAX:   level_max_r   <= $signed(cfg_wdata[LEVEL_W-1:0]);
        CFG_START_PHASE: start_phase_r <= cfg_wdata[PW-1:0];
        default: ;
      endcase
    end
  end

  // sequencer
  logic [STEP_W-1:0] step_r, step_nxt;
  logic              out_valid_r, out_valid_nxt;
  uword_t            uw;
  logic              go;
  dp_ctrl_t          en;

  always_comb begin
    uw = ucode(step_r);
    unique case (uw.cond)
      COND_ALWAYS: go = 1'b1;
      COND_IN:     go = in_valid && rst_n;
      COND_OUT:    go = !out_valid_r || !out_stall;
      default:     go = 1'b1;
    endcase
    en       = go ? uw.en : '0;
    step_nxt = go ? uw.next : step_r;
    out_valid_nxt = out_valid_r;
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
    if (en.ld_out) begin
      out_valid_nxt = 1'b1;
    end
  end

  assign in_stall  = !rst_n || (uw.cond != COND_IN);
  assign out_valid = out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r      <= STEP_ACCEPT;
      out_valid_r <= 1'b0;
    end else begin
      step_r      <= step_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  msto_datapath #(
    .PHASE_FRAC_BITS (PHASE_FRAC_BITS),
    .SAMPLE_BITS     (SAMPLE_BITS)
  ) u_datapath (
    .clk         (clk),
    .rst_n       (rst_n),
    .ctrl        (en),
    .restart     (in_restart),
    .mode        (wave_mode_r),
    .phase_inc   (phase_inc_r),
    .aux_rate    (aux_rate_r),
    .shape_a     (shape_a_r),
    .shape_b     (shape_b_r),
    .start_phase (start_phase_r),
    .level_min   (level_min_r),
    .level_max   (level_max_r),
    .sample      (out_sample),
    .phase_now   (out_phase_now)
  );

endmodule
